>>> sv/dttfp_pkg.sv
`timescale 1ns / 1ps

package dttfp_pkg;

   // Character codes recognised by the parser
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   // Largest decimal exponent whose power of ten fits in 64 bits
   localparam logic [4:0] MAX_SCALE_EXP  = 5'd19;
   // Fraction digit count saturates here
   localparam logic [4:0] FRAC_COUNT_MAX = 5'd31;

   // One scaling job handed from the parser to the scaler
   typedef struct packed {
      logic [63:0] digits;
      logic [63:0] scale;
      logic        ok;
   } scale_job_type;

   // Ten to the given exponent; exponents above the table give one.
   function automatic logic [63:0] pow10(input logic [4:0] exponent);
      logic [63:0] value;
      case (exponent)
         5'd0:    value = 64'd1;
         5'd1:    value = 64'd10;
         5'd2:    value = 64'd100;
         5'd3:    value = 64'd1000;
         5'd4:    value = 64'd10000;
         5'd5:    value = 64'd100000;
         5'd6:    value = 64'd1000000;
         5'd7:    value = 64'd10000000;
         5'd8:    value = 64'd100000000;
         5'd9:    value = 64'd1000000000;
         5'd10:   value = 64'd10000000000;
         5'd11:   value = 64'd100000000000;
         5'd12:   value = 64'd1000000000000;
         5'd13:   value = 64'd10000000000000;
         5'd14:   value = 64'd100000000000000;
         5'd15:   value = 64'd1000000000000000;
         5'd16:   value = 64'd10000000000000000;
         5'd17:   value = 64'd100000000000000000;
         5'd18:   value = 64'd1000000000000000000;
         5'd19:   value = 64'd10000000000000000000;
         default: value = 64'd1;
      endcase
      return value;
   endfunction

endpackage

>>> sv/decimal_text_to_fixed_point_top.sv
`timescale 1ns / 1ps
// Parses an unsigned ASCII decimal amount, one character per transaction.
// Throughput: one transaction per cycle while req_tready is high; a job the scaler has not taken holds it low.
// After the end-marker transaction, the result passes the job register and then the three stages of the
// 64 x 64 scaling multiplier (partial products, middle sum, result register) before it appears on rsp.
// Reset: synchronous, active high; clears the text state, pipeline and decimal_places to zero.

module decimal_text_to_fixed_point_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data,     // decimal_places
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] scaled_value
   output logic        rsp_tuser     // [0] valid_res
);

   logic [4:0] places_ff, places_in;
   logic       job_valid;
   logic       job_ready;
   dttfp_pkg::scale_job_type job;

   // Decimal places register, always writable
   assign csr_ready = 1'b1;
   assign places_in = (csr_valid && csr_ready) ? csr_data : places_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         places_ff <= '0;
      end else begin
         places_ff <= places_in;
      end
   end

   dttfp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .decimal_places (places_ff),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .job_valid      (job_valid),
      .job_ready      (job_ready),
      .job            (job)
   );

   dttfp_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> sv/dttfp_parser.sv
`timescale 1ns / 1ps

module dttfp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [4:0]              decimal_places,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // char_code
   input  logic                    req_tlast,   // end_marker
   output logic                    job_valid,
   input  logic                    job_ready,
   output dttfp_pkg::scale_job_type job
);

   logic [63:0] digits_ff, digits_in;
   logic        range_ff, range_in;
   logic        in_frac_ff, in_frac_in;
   logic [4:0]  frac_count_ff, frac_count_in;
   logic        saw_whole_ff, saw_whole_in;
   logic        malformed_ff, malformed_in;
   logic        job_valid_ff, job_valid_in;
   dttfp_pkg::scale_job_type job_ff, job_in;

   logic        accept;
   logic        is_digit;
   logic [7:0]  char_offset;
   logic [67:0] times_ten_sum;
   logic        text_ok;

   // The job slot frees when it is empty or being handed on
   assign req_tready = !job_valid_ff || job_ready;
   assign accept     = req_tvalid && req_tready;

   // Digit decode and the accumulate step: digits * 10 + digit
   assign is_digit      = (req_tdata >= dttfp_pkg::CHAR_ZERO) &&
                          (req_tdata <= dttfp_pkg::CHAR_NINE);
   assign char_offset   = req_tdata - dttfp_pkg::CHAR_ZERO;
   assign times_ten_sum = ({4'd0, digits_ff} << 3) + ({4'd0, digits_ff} << 1) +
                          {64'd0, char_offset[3:0]};

   // Result checks that do not need the final product
   assign text_ok = saw_whole_ff && !malformed_ff && !range_ff &&
                    (decimal_places <= dttfp_pkg::MAX_SCALE_EXP) &&
                    (frac_count_ff <= decimal_places);

   // Next text state
   always_comb begin
      digits_in     = digits_ff;
      range_in      = range_ff;
      in_frac_in    = in_frac_ff;
      frac_count_in = frac_count_ff;
      saw_whole_in  = saw_whole_ff;
      malformed_in  = malformed_ff;
      if (accept) begin
         if (req_tlast) begin
            digits_in     = '0;
            range_in      = 1'b0;
            in_frac_in    = 1'b0;
            frac_count_in = '0;
            saw_whole_in  = 1'b0;
            malformed_in  = 1'b0;
         end else if (is_digit) begin
            if (!range_ff) begin
               if (times_ten_sum[67:64] != 4'd0) begin
                  range_in = 1'b1;
               end else begin
                  digits_in = times_ten_sum[63:0];
               end
            end
            if (in_frac_ff) begin
               if (frac_count_ff != dttfp_pkg::FRAC_COUNT_MAX) begin
                  frac_count_in = frac_count_ff + 5'd1;
               end
            end else begin
               saw_whole_in = 1'b1;
            end
         end else if ((req_tdata == dttfp_pkg::CHAR_DOT) && !in_frac_ff) begin
            in_frac_in = 1'b1;
         end else begin
            malformed_in = 1'b1;
         end
      end
   end

   // Job slot control and contents
   always_comb begin
      job_valid_in = job_valid_ff;
      if (accept && req_tlast) begin
         job_valid_in = 1'b1;
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end
      job_in        = job_ff;
      if (accept && req_tlast) begin
         job_in.digits = digits_ff;
         job_in.scale  = dttfp_pkg::pow10(decimal_places - frac_count_ff);
         job_in.ok     = text_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff     <= '0;
         range_ff      <= 1'b0;
         in_frac_ff    <= 1'b0;
         frac_count_ff <= '0;
         saw_whole_ff  <= 1'b0;
         malformed_ff  <= 1'b0;
         job_valid_ff  <= 1'b0;
      end else begin
         digits_ff     <= digits_in;
         range_ff      <= range_in;
         in_frac_ff    <= in_frac_in;
         frac_count_ff <= frac_count_in;
         saw_whole_ff  <= saw_whole_in;
         malformed_ff  <= malformed_in;
         job_valid_ff  <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

>>> sv/dttfp_scaler.sv
`timescale 1ns / 1ps

module dttfp_scaler (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  dttfp_pkg::scale_job_type job,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,   // scaled_value
   output logic                    rsp_tuser    // valid_res
);

   // Partial product stage
   logic        pp_valid_ff, pp_valid_in;
   logic [63:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic        pp_ok_ff;

   // Middle sum stage
   logic        mid_valid_ff, mid_valid_in;
   logic [64:0] mid_sum_ff;
   logic [63:0] mid_ll_ff;
   logic        mid_high_nz_ff;
   logic        mid_ok_ff;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_value_ff, out_value_in;
   logic        out_ok_ff, out_ok_in;

   logic        out_ready, mid_ready, pp_ready;
   logic [96:0] full_low;
   logic        overflow;

   // Each stage moves on when it is empty or the next one takes its contents
   assign out_ready = !out_valid_ff || rsp_tready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign pp_ready  = !pp_valid_ff || mid_ready;
   assign job_ready = pp_ready;

   assign pp_valid_in  = pp_ready ? job_valid : pp_valid_ff;
   assign mid_valid_in = mid_ready ? pp_valid_ff : mid_valid_ff;
   assign out_valid_in = out_ready ? mid_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff  <= pp_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Four 32 x 32 partial products of digits * scale
   always_ff @(posedge clock) begin
      if (pp_ready) begin
         pp_ll_ff <= job.digits[31:0]  * job.scale[31:0];
         pp_lh_ff <= job.digits[31:0]  * job.scale[63:32];
         pp_hl_ff <= job.digits[63:32] * job.scale[31:0];
         pp_hh_ff <= job.digits[63:32] * job.scale[63:32];
         pp_ok_ff <= job.ok;
      end
   end

   // Cross terms summed; the high term only matters as nonzero
   always_ff @(posedge clock) begin
      if (mid_ready) begin
         mid_sum_ff     <= {1'b0, pp_lh_ff} + {1'b0, pp_hl_ff};
         mid_ll_ff      <= pp_ll_ff;
         mid_high_nz_ff <= (pp_hh_ff != 64'd0);
         mid_ok_ff      <= pp_ok_ff;
      end
   end

   // Final add, overflow past 64 bits and the zeroed invalid result
   assign full_low = {33'd0, mid_ll_ff} + {mid_sum_ff, 32'd0};
   assign overflow = mid_high_nz_ff || (full_low[96:64] != 33'd0);

   always_comb begin
      out_ok_in    = out_ok_ff;
      out_value_in = out_value_ff;
      if (out_ready) begin
         out_ok_in    = mid_ok_ff && !overflow;
         out_value_in = (mid_ok_ff && !overflow) ? full_low[63:0] : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      out_ok_ff    <= out_ok_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_ok_ff;

endmodule
